>>> rtl/atwsc_pkg.sv
// Shared types and constants for the anti-lock and traction wheel slip controller.
package atwsc_pkg;

   // Number of wheel speeds carried by every item.
   localparam int unsigned NUM_SPEEDS = 4;
   // Default number of wheels that keep a pair of flags.
   localparam int unsigned NUM_WHEELS_DEF = 4;

   // Level threshold (0.1 in Q12), minimum anti-lock speed (6.0 rad/s in Q9.6)
   // and minimum traction spread (1.0 rad/s in Q9.6).
   localparam logic [12:0]        LEVEL_THRESH   = 13'd409;
   localparam logic signed [15:0] ABS_MIN_SPEED  = 16'sd384;
   localparam logic signed [16:0] TCS_MIN_SPREAD = 17'sd64;

   // Clutch saturation limit, 1.0 in Q12.
   localparam logic signed [13:0] CLUTCH_ONE = 14'sd4096;
   // Throttle cut clamp, 1.0 in Q24, and the rounding offset of the Q12 shift.
   localparam logic signed [35:0] CUT_MAX    = 36'sd16777216;
   localparam logic [25:0]        CUT_ROUND  = 26'd2048;

   // Update kinds.
   localparam logic OP_ABS = 1'b0;
   localparam logic OP_TCS = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_ABS_ENABLE = 1'b0;
   localparam logic CSR_TCS_ENABLE = 1'b1;

   typedef logic signed [15:0] speed_type;

   // Per-item values that do not depend on the stored flags.
   typedef struct packed {
      logic               op;
      logic [1:0]         wheel;
      logic               level_ok;
      logic               err_pos;
      logic               err_neg;
      logic signed [17:0] error;
      logic [15:0]        clutch10;
      logic [12:0]        brake;
      logic [12:0]        gas;
   } s1_type;

   // Per-item values after the flag update and the cut product.
   typedef struct packed {
      logic               wheel_active;
      logic               abs_any;
      logic               tcs_any;
      logic               cut_en;
      logic [12:0]        brake_out;
      logic [12:0]        gas;
      logic signed [34:0] prod;
   } s2_type;

endpackage

>>> rtl/atwsc_lane.sv
// One speed lane: compares its wheel speed against the anti-lock floor and the selected wheel.
module atwsc_lane
   import atwsc_pkg::*;
(
   input  logic      clock,
   input  logic      en,
   input  speed_type speed,
   input  speed_type speed_ref,
   output logic      fast,
   output logic      spread
);

   logic signed [16:0] diff;
   logic               fast_in;
   logic               spread_in;
   logic               fast_ff;
   logic               spread_ff;

   // Speed above the anti-lock floor, and spread to the selected wheel above one rad/s.
   always_comb begin
      diff      = 17'(speed_ref) - 17'(speed);
      fast_in   = speed > ABS_MIN_SPEED;
      spread_in = (diff > TCS_MIN_SPREAD) || (diff < -TCS_MIN_SPREAD);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fast_ff   <= fast_in;
         spread_ff <= spread_in;
      end
   end

   assign fast   = fast_ff;
   assign spread = spread_ff;

endmodule

>>> rtl/atwsc_flags.sv
// Merges the lane results, updates the per-wheel flags and forms the throttle cut product.
module atwsc_flags
   import atwsc_pkg::*;
#(
   parameter int unsigned NUM_WHEELS = NUM_WHEELS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  s1_type                s1,
   input  logic [NUM_SPEEDS-1:0] fast,
   input  logic [NUM_SPEEDS-1:0] spread,
   input  logic                  abs_enable,
   input  logic                  tcs_enable,
   output s2_type                s2
);

   logic [NUM_WHEELS-1:0] abs_flags_ff;
   logic [NUM_WHEELS-1:0] tcs_flags_ff;
   logic [NUM_WHEELS-1:0] abs_flags_in;
   logic [NUM_WHEELS-1:0] tcs_flags_in;
   logic                  hit;
   logic                  cur;
   logic                  speed_ok;
   logic                  f_new;
   s2_type                s2_in;
   s2_type                s2_ff;

   // Merge the lanes, read the selected flag and work out its new value.
   always_comb begin
      hit          = 1'b0;
      cur          = 1'b0;
      abs_flags_in = abs_flags_ff;
      tcs_flags_in = tcs_flags_ff;
      speed_ok     = (s1.op == OP_TCS) ? (|spread) : (|fast);
      for (int i = 0; i < NUM_WHEELS; i++) begin
         if (32'(s1.wheel) == i) begin
            hit = 1'b1;
            cur = (s1.op == OP_TCS) ? tcs_flags_ff[i] : abs_flags_ff[i];
         end
      end
      f_new = s1.level_ok && speed_ok && (cur || s1.err_pos) && !s1.err_neg;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         if (32'(s1.wheel) == i) begin
            if (s1.op == OP_TCS) begin
               tcs_flags_in[i] = f_new;
            end else begin
               abs_flags_in[i] = f_new;
            end
         end
      end
      s2_in.wheel_active = hit && f_new;
      s2_in.abs_any      = abs_enable && (|abs_flags_in);
      s2_in.tcs_any      = tcs_enable && (|tcs_flags_in);
      s2_in.cut_en       = (s1.op == OP_TCS) && hit && f_new;
      s2_in.brake_out    = ((s1.op == OP_ABS) && hit && f_new) ? 13'd0 : s1.brake;
      s2_in.gas          = s1.gas;
      s2_in.prod         = s1.error * $signed({1'b0, s1.clutch10});
   end

   // Flag state changes only when an item moves into this stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         abs_flags_ff <= '0;
         tcs_flags_ff <= '0;
      end else if (take) begin
         abs_flags_ff <= abs_flags_in;
         tcs_flags_ff <= tcs_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

>>> rtl/abs_tcs_wheel_slip_controller_top.sv
// Top level of the anti-lock and traction wheel slip controller.
//
//   Channel  Direction  Ports                       Contents
//   req      in         req_tvalid/tready/tdata/tuser  one wheel update per item
//   rsp      out        rsp_tvalid/tready/tdata     flags and brake/throttle outputs
//   csr      in         csr_valid/ready/addr/wdata  abs_enable (0), tcs_enable (1)
//
// One item is accepted per cycle while req_tready is high; its result passes
// through every stage below, each registered, before it is valid on rsp.
// The stages are: speed lanes and slip error, flag update with the cut multiplier,
// then the throttle clamp and rounding into the output register.
// Reset clears all flags and both enables. A stall on rsp fills the stages from the
// output back, and req_tready falls only when every stage holds an item.
module abs_tcs_wheel_slip_controller_top
   import atwsc_pkg::*;
#(
   parameter int unsigned NUM_WHEELS = NUM_WHEELS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   // Fields from bit 0: wheel, speed_w0, speed_w1, speed_w2, speed_w3, slide,
   // ideal_slide, brake_level, throttle_level, clutch_level, reverse_gear, zero fill.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,
   // Fields from bit 0: op.
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: wheel_active, abs_any_active, tcs_any_active, brake_out,
   // throttle_out, zero fill.
   output logic [31:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_addr,
   input  logic         csr_wdata
);

   speed_type             speeds [NUM_SPEEDS];
   speed_type             speed_ref;
   logic signed [15:0]    slide;
   logic [14:0]           ideal;
   logic [12:0]           brake;
   logic [12:0]           gas;
   logic signed [13:0]    clutch;
   logic                  reverse;
   logic                  op;
   logic [1:0]            wheel;
   logic signed [17:0]    slide_e;
   logic signed [18:0]    neg_ideal;
   logic [12:0]           clutch_sat;
   s1_type                s1_in;
   s1_type                s1_ff;
   logic [NUM_SPEEDS-1:0] fast;
   logic [NUM_SPEEDS-1:0] spread;
   s2_type                s2;
   logic                  v1_ff;
   logic                  v2_ff;
   logic                  v3_ff;
   logic                  en1;
   logic                  en2;
   logic                  en3;
   logic                  abs_enable_ff;
   logic                  tcs_enable_ff;
   logic signed [35:0]    cut_v;
   logic [24:0]           cut_c;
   logic [25:0]           cut_r;
   logic [31:0]           rsp_in;
   logic [31:0]           rsp_ff;

   // Unpack the input item.
   always_comb begin
      op        = req_tuser;
      wheel     = req_tdata[1:0];
      speeds[0] = req_tdata[17:2];
      speeds[1] = req_tdata[33:18];
      speeds[2] = req_tdata[49:34];
      speeds[3] = req_tdata[65:50];
      slide     = req_tdata[81:66];
      ideal     = req_tdata[96:82];
      brake     = req_tdata[109:97];
      gas       = req_tdata[122:110];
      clutch    = req_tdata[136:123];
      reverse   = req_tdata[137];
      speed_ref = speeds[wheel];
   end

   // Stage handshake: each stage moves when the one after it is empty or moving.
   assign en3        = !v3_ff || rsp_tready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_enable_ff <= 1'b0;
         tcs_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_addr)
            CSR_ABS_ENABLE: abs_enable_ff <= csr_wdata;
            CSR_TCS_ENABLE: tcs_enable_ff <= csr_wdata;
            default:        abs_enable_ff <= abs_enable_ff;
         endcase
      end
   end

   // Slip error, its two thresholds, the level check and the scaled clutch.
   always_comb begin
      slide_e   = ((op == OP_ABS) || reverse) ? -18'(slide) : 18'(slide);
      neg_ideal = -$signed({4'b0, ideal});
      if (clutch < 14'sd0) begin
         clutch_sat = 13'd0;
      end else if (clutch > CLUTCH_ONE) begin
         clutch_sat = 13'(CLUTCH_ONE);
      end else begin
         clutch_sat = clutch[12:0];
      end
      s1_in.op       = op;
      s1_in.wheel    = wheel;
      s1_in.level_ok = ((op == OP_TCS) ? gas : brake) > LEVEL_THRESH;
      s1_in.error    = slide_e - $signed({3'b0, ideal});
      s1_in.err_pos  = s1_in.error > 18'sd0;
      s1_in.err_neg  = $signed({s1_in.error, 1'b0}) < neg_ideal;
      s1_in.clutch10 = {clutch_sat, 3'b0} + {2'b0, clutch_sat, 1'b0};
      s1_in.brake    = brake;
      s1_in.gas      = gas;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= s1_in;
      end
   end

   // One lane per wheel speed.
   for (genvar k = 0; k < NUM_SPEEDS; k++) begin : g_lane
      atwsc_lane u_lane (
         .clock     (clock),
         .en        (en1),
         .speed     (speeds[k]),
         .speed_ref (speed_ref),
         .fast      (fast[k]),
         .spread    (spread[k])
      );
   end

   // Lane merge and flag update.
   atwsc_flags #(
      .NUM_WHEELS (NUM_WHEELS)
   ) u_flags (
      .clock      (clock),
      .reset      (reset),
      .take       (en2 && v1_ff),
      .s1         (s1_ff),
      .fast       (fast),
      .spread     (spread),
      .abs_enable (abs_enable_ff),
      .tcs_enable (tcs_enable_ff),
      .s2         (s2)
   );

   // Throttle cut: clamp the Q24 value to 0..1 and round to Q12.
   always_comb begin
      cut_v = $signed({11'b0, s2.gas, 12'b0}) - $signed({s2.prod[34], s2.prod});
      if (cut_v < 36'sd0) begin
         cut_c = 25'd0;
      end else if (cut_v > CUT_MAX) begin
         cut_c = 25'(CUT_MAX);
      end else begin
         cut_c = cut_v[24:0];
      end
      cut_r  = {1'b0, cut_c} + CUT_ROUND;
      rsp_in = {3'b0,
                s2.cut_en ? cut_r[24:12] : s2.gas,
                s2.brake_out,
                s2.tcs_any,
                s2.abs_any,
                s2.wheel_active};
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

>>> verif/tb_abs_tcs_wheel_slip_controller_top.sv
// Self-checking testbench for the anti-lock and traction wheel slip controller.
`timescale 1ns / 100ps

module tb_abs_tcs_wheel_slip_controller_top;
   import atwsc_pkg::*;

   // Thresholds of the control law: 0.1 in Q12, 6.0 rad/s and 1.0 rad/s in Q9.6.
   localparam int LEVEL_MIN    = 409;
   localparam int LOCK_SPEED   = 384;
   localparam int SPIN_SPREAD  = 64;
   localparam int Q12_ONE      = 4096;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int NUM_PHASES   = 6;

   // One wheel update as it travels on the request channel.
   typedef struct packed {
      logic               op;
      logic [1:0]         wheel;
      logic [3:0][15:0]   speed;
      logic signed [15:0] slide;
      logic [14:0]        ideal;
      logic [12:0]        brake;
      logic [12:0]        gas;
      logic signed [13:0] clutch;
      logic               reverse;
   } wheel_update_type;

   // One result item.
   typedef struct packed {
      logic        wheel_active;
      logic        abs_any;
      logic        tcs_any;
      logic [12:0] brake_out;
      logic [12:0] throttle_out;
   } wheel_result_type;

   // A row of the directed table; known rows carry a hand-written expectation.
   typedef struct packed {
      wheel_update_type upd;
      logic             known;
      wheel_result_type res;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_addr = 1'b0;
   logic         csr_wdata = 1'b0;

   // Predictor state: the per-wheel flags and the two enables.
   logic [3:0]   abs_lock_flag = '0;
   logic [3:0]   tcs_slip_flag = '0;
   logic         abs_en_reg = 1'b0;
   logic         tcs_en_reg = 1'b0;

   wheel_result_type pending_wheel_outputs[$];
   directed_row_type directed_rows[$];
   int               mismatch_count = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;

   abs_tcs_wheel_slip_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // The run is abandoned if it has not finished well after the slowest correct run.
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Engage on a positive error, release below minus half the ideal slide.
   function automatic logic slip_flag_next(input logic flag, input int err, input int ideal);
      logic f;
      f = flag;
      if (err > 0)
         f = 1'b1;
      if (2 * err < -ideal)
         f = 1'b0;
      return f;
   endfunction

   // Applies one update to the flag state and works out the outputs it produces.
   function automatic wheel_result_type apply_slip_control(input wheel_update_type u);
      wheel_result_type r;
      int               spd[4];
      int               slide_v, ideal_v, brake_v, gas_v, err, top, spread, d;
      longint           c, v;
      logic             flag;
      for (int k = 0; k < 4; k++)
         spd[k] = $signed(u.speed[k]);
      slide_v = $signed(u.slide);
      ideal_v = int'(u.ideal);
      brake_v = int'(u.brake);
      gas_v   = int'(u.gas);
      r.brake_out    = u.brake;
      r.throttle_out = u.gas;
      if (u.op == OP_ABS) begin
         flag = abs_lock_flag[u.wheel];
         if (brake_v > LEVEL_MIN) begin
            top = 0;
            for (int k = 0; k < 4; k++)
               if (spd[k] > top)
                  top = spd[k];
            if (top > LOCK_SPEED)
               flag = slip_flag_next(flag, -slide_v - ideal_v, ideal_v);
            else
               flag = 1'b0;
         end else begin
            flag = 1'b0;
         end
         abs_lock_flag[u.wheel] = flag;
         if (flag)
            r.brake_out = '0;
      end else begin
         flag = tcs_slip_flag[u.wheel];
         if (gas_v > LEVEL_MIN) begin
            spread = 0;
            for (int k = 0; k < 4; k++) begin
               d = spd[u.wheel] - spd[k];
               if (d < 0)
                  d = -d;
               if (d > spread)
                  spread = d;
            end
            if (spread > SPIN_SPREAD) begin
               err = (u.reverse ? -slide_v : slide_v) - ideal_v;
               flag = slip_flag_next(flag, err, ideal_v);
               if (flag) begin
                  // Throttle cut in Q24, clamped to 0..1 and rounded back to Q12.
                  c = $signed(u.clutch);
                  if (c > Q12_ONE)
                     c = Q12_ONE;
                  if (c < 0)
                     c = 0;
                  v = longint'(gas_v) * Q12_ONE - longint'(err) * 10 * c;
                  if (v < 0)
                     v = 0;
                  if (v > longint'(Q12_ONE) * Q12_ONE)
                     v = longint'(Q12_ONE) * Q12_ONE;
                  r.throttle_out = 13'((v + 2048) >>> 12);
               end
            end else begin
               flag = 1'b0;
            end
         end else begin
            flag = 1'b0;
         end
         tcs_slip_flag[u.wheel] = flag;
      end
      r.wheel_active = flag;
      r.abs_any = abs_en_reg && (|abs_lock_flag);
      r.tcs_any = tcs_en_reg && (|tcs_slip_flag);
      return r;
   endfunction

   // Builds one directed row; a known row expects no flag and both levels passed through.
   function automatic directed_row_type slip_row(input logic op, input logic [1:0] wheel,
         input int s0, input int s1, input int s2, input int s3, input int slide,
         input int ideal, input int brake, input int gas, input int clutch,
         input logic reverse, input logic known);
      directed_row_type row;
      row.upd.op      = op;
      row.upd.wheel   = wheel;
      row.upd.speed   = {16'(s3), 16'(s2), 16'(s1), 16'(s0)};
      row.upd.slide   = 16'(slide);
      row.upd.ideal   = 15'(ideal);
      row.upd.brake   = 13'(brake);
      row.upd.gas     = 13'(gas);
      row.upd.clutch  = 14'(clutch);
      row.upd.reverse = reverse;
      row.known       = known;
      row.res         = {1'b0, 1'b0, 1'b0, 13'(brake), 13'(gas)};
      return row;
   endfunction

   // Appends one row to the directed table.
   task automatic add_row(input directed_row_type row);
      directed_rows = {directed_rows, row};
   endtask

   // Random update: mostly well-formed control situations, some fully random items.
   function automatic wheel_update_type random_update();
      wheel_update_type u;
      int               ideal_v, err_v, mag;
      u.op    = 1'($urandom_range(0, 1));
      u.wheel = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
         u.speed   = {$urandom, $urandom};
         u.slide   = 16'($urandom);
         u.ideal   = 15'($urandom);
         u.brake   = 13'($urandom);
         u.gas     = 13'($urandom);
         u.clutch  = 14'($urandom);
         u.reverse = 1'($urandom);
      end else begin
         for (int k = 0; k < 4; k++)
            u.speed[k] = 16'(int'($urandom_range(0, 3000)) - 500);
         ideal_v   = int'($urandom_range(0, 1500));
         err_v     = int'($urandom_range(0, 4000)) - 2000;
         mag       = err_v + ideal_v;
         u.reverse = ($urandom_range(0, 3) == 0);
         u.ideal   = 15'(ideal_v);
         // Choose the slide so that the slip error lands near the switching points.
         if (u.op == OP_ABS)
            u.slide = 16'(-mag);
         else
            u.slide = 16'(u.reverse ? -mag : mag);
         u.brake  = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(300, 4096));
         u.gas    = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(300, 4096));
         u.clutch = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 4500));
      end
      return u;
   endfunction

   // Offers one item, with random idle cycles before it, and records its expectation.
   task automatic send_update(input wheel_update_type u, input logic known,
         input wheel_result_type known_res);
      wheel_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {6'b0, u.reverse, u.clutch, u.gas, u.brake, u.ideal, u.slide, u.speed,
                     u.wheel};
      req_tuser  <= u.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = apply_slip_control(u);
      if (known)
         predicted = known_res;
      pending_wheel_outputs = {pending_wheel_outputs, predicted};
   endtask

   // Stops sending and waits until every expected result has arrived.
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      while (pending_wheel_outputs.size() != 0)
         @(posedge clock);
   endtask

   // Writes both enables back to back, holding valid high across the two items.
   task automatic write_enables(input logic abs_val, input logic tcs_val);
      csr_addr  <= CSR_ABS_ENABLE;
      csr_wdata <= abs_val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_addr  <= CSR_TCS_ENABLE;
      csr_wdata <= tcs_val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      abs_en_reg = abs_val;
      tcs_en_reg = tcs_val;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result side: check each accepted item, then choose the next ready at random.
   always @(posedge clock) begin : rsp_monitor
      wheel_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.wheel_active = rsp_tdata[0];
         got.abs_any      = rsp_tdata[1];
         got.tcs_any      = rsp_tdata[2];
         got.brake_out    = rsp_tdata[15:3];
         got.throttle_out = rsp_tdata[28:16];
         if (pending_wheel_outputs.size() == 0) begin
            $error("result item arrived with no expectation waiting");
            mismatch_count++;
         end else begin
            want = pending_wheel_outputs.pop_front();
            compare_field("wheel_active", want.wheel_active, got.wheel_active);
            compare_field("abs_any_active", want.abs_any, got.abs_any);
            compare_field("tcs_any_active", want.tcs_any, got.tcs_any);
            compare_field("brake_out", want.brake_out, got.brake_out);
            compare_field("throttle_out", want.throttle_out, got.throttle_out);
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Stimulus: reset, directed table, then random phases over enables and idling.
   initial begin : stimulus
      int               phase_send[NUM_PHASES];
      int               phase_stall[NUM_PHASES];
      logic             phase_abs[NUM_PHASES];
      logic             phase_tcs[NUM_PHASES];
      wheel_result_type unused_res;
      phase_send  = '{0, 55, 0, 18, 0, 18};
      phase_stall = '{0, 0, 55, 18, 0, 18};
      phase_abs   = '{0, 1, 0, 1, 0, 1};
      phase_tcs   = '{0, 0, 1, 1, 0, 1};
      unused_res  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_enables(1'b1, 1'b1);

      // Clearing conditions first: levels at 0.1, no speed, speed exactly 6.0,
      // spread exactly 1.0 and equal speeds. All flags are still clear here.
      add_row(slip_row(OP_ABS, 0, 1000, 1000, 1000, 1000, -2000, 100,
                       409, 4096, 4096, 0, 1));
      add_row(slip_row(OP_ABS, 1, -32768, -32768, -32768, -32768, -32768, 0,
                       4096, 0, 0, 0, 1));
      add_row(slip_row(OP_ABS, 2, 384, 384, -5, 0, -32768, 0,
                       8191, 8191, -8192, 1, 1));
      add_row(slip_row(OP_TCS, 0, 2000, 0, 0, 0, 1000, 0,
                       0, 409, 4096, 0, 1));
      add_row(slip_row(OP_TCS, 3, 0, 0, 0, 64, 1000, 0,
                       4096, 4096, 4096, 0, 1));
      add_row(slip_row(OP_TCS, 1, 100, 100, 100, 100, 30000, 0,
                       4096, 4096, 4096, 0, 1));
      // Anti-lock: engage, hold at zero error, release, levels above 1.0,
      // and the hold exactly at minus half the ideal slide.
      add_row(slip_row(OP_ABS, 1, 385, 0, 0, 0, -32768, 0,
                       4096, 0, 0, 0, 0));
      add_row(slip_row(OP_ABS, 1, 385, 0, 0, 0, 0, 0,
                       4096, 4096, 0, 0, 0));
      add_row(slip_row(OP_ABS, 1, 32767, 0, 0, 0, 32767, 32767,
                       4096, 4096, 0, 0, 0));
      add_row(slip_row(OP_ABS, 2, 500, 0, 0, 0, -3000, 2000,
                       8191, 8191, 0, 0, 0));
      add_row(slip_row(OP_ABS, 2, 500, 0, 0, 0, -500, 1000,
                       4096, 4096, 0, 0, 0));
      add_row(slip_row(OP_ABS, 3, 0, 0, 0, 1000, 1, 2,
                       4096, 4096, 0, 0, 0));
      add_row(slip_row(OP_ABS, 0, 0, 32767, 0, 0, -32768, 32767,
                       4096, 4096, 0, 0, 0));
      // Traction: full cut, reverse gear with the clutch saturated low, a partial
      // cut, the clamp above 1.0, release, rounding and a reverse-gear release.
      add_row(slip_row(OP_TCS, 0, 32767, -32768, 0, 0, 32767, 0,
                       0, 4096, 8191, 0, 0));
      add_row(slip_row(OP_TCS, 1, 0, 32767, 0, 0, -32768, 0,
                       4096, 4096, -8192, 1, 0));
      add_row(slip_row(OP_TCS, 2, 0, 0, 1000, 0, 100, 50,
                       4096, 4096, 4096, 0, 0));
      add_row(slip_row(OP_TCS, 2, 0, 0, 1000, 0, 0, 0,
                       8191, 8191, 4096, 0, 0));
      add_row(slip_row(OP_TCS, 2, 0, 0, 1000, 0, -32768, 32767,
                       8191, 8191, 4096, 0, 0));
      add_row(slip_row(OP_TCS, 3, 0, 0, 0, 900, 3, 1,
                       4096, 3000, 1, 0, 0));
      add_row(slip_row(OP_TCS, 0, 900, 0, 0, 0, 5, 10,
                       4096, 3000, 2048, 1, 0));
      foreach (directed_rows[i])
         send_update(directed_rows[i].upd, directed_rows[i].known, directed_rows[i].res);
      drain_outputs();

      // Random phases, each with its own enable setting and idling pattern.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_enables(phase_abs[p], phase_tcs[p]);
         send_idle_pct = phase_send[p];
         rsp_stall_pct = phase_stall[p];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Once in the run the sender holds off until the pipeline is empty.
            if (p == 2 && n == ITEMS_PER_PHASE / 2)
               drain_outputs();
            send_update(random_update(), 1'b0, unused_res);
         end
         drain_outputs();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_wheel_outputs.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
